### sv/sobel_pkg.sv
// Shared constants and controller/datapath interface types for the Sobel edge block.
package sobel_pkg;

  localparam int MAX_ROW_WIDTH = 2048;
  localparam int LINE_AW       = $clog2(MAX_ROW_WIDTH);
  localparam int ROW_W         = 12;
  localparam int GAIN_W        = 16;
  localparam int PIX_W         = 8;
  localparam int ROWCNT_W      = 16;
  localparam int GRAD_W        = 10;
  localparam int RAD_W         = 29;
  localparam int ROOT_W        = 15;
  localparam int PROD_W        = ROOT_W + GAIN_W;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 1'd1;

  localparam logic [ROW_W-1:0]  ROW_WIDTH_RST = 12'd2048;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd256;
  localparam logic [ROW_W-1:0]  ROW_WIDTH_MIN = 12'd3;

  typedef struct packed {
    logic accept;
    logic rd;
    logic upd;
    logic grad;
    logic sqr;
    logic root_step;
    logic mul;
    logic load_out;
    logic clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic emit;
    logic root_last;
    logic out_free;
  } ctl_sts_t;

endpackage

### sv/sobel_ctrl.sv
// Sequencing state machine for the Sobel edge block.
module sobel_ctrl
  import sobel_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_GRAD  = 4'd4;
  localparam logic [3:0] S_SQR   = 4'd5;
  localparam logic [3:0] S_ROOT  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = sts.emit ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = S_SQR;
      end
      S_SQR: begin
        cmd.sqr    = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten");

  a_ready_idle_only: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.rd || cmd.upd || cmd.root_step || cmd.clear))
    else $error("input ready while busy");

  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    state <= S_OUT)
    else $error("controller state out of range");

endmodule

### sv/sobel_dp.sv
// Datapath: line stores, window, gradient, square root, gain and result register.
module sobel_dp
  import sobel_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             cmd,
  output ctl_sts_t             sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [PIX_W-1:0]     gray_in,
  input  logic                 frame_start,
  input  logic                 frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     edge_value,
  output logic                 last_result
);

  logic [ROW_W-1:0]    row_width;
  logic [GAIN_W-1:0]   gain;
  logic [ROW_W-1:0]    width_eff;

  logic [PIX_W-1:0]    line0 [MAX_ROW_WIDTH];
  logic [PIX_W-1:0]    line1 [MAX_ROW_WIDTH];
  logic [LINE_AW-1:0]  clr_addr;
  logic [PIX_W-1:0]    top_q;
  logic [PIX_W-1:0]    mid_q;
  logic [PIX_W-1:0]    pix;
  logic                end_q;
  logic                last_q;

  logic [LINE_AW-1:0]  col;
  logic [ROWCNT_W-1:0] row;
  logic [LINE_AW-1:0]  col_start;
  logic [ROWCNT_W-1:0] row_start;
  logic [ROW_W-1:0]    col_inc;

  logic [PIX_W-1:0]    win [3][3];

  logic signed [10:0]  gx;
  logic signed [10:0]  gy;
  logic [GRAD_W-1:0]   ax;
  logic [GRAD_W-1:0]   ay;

  logic [RAD_W-1:0]    rad;
  logic [RAD_W-1:0]    res;
  logic [RAD_W-1:0]    rbit;
  logic [RAD_W:0]      trial;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-13:0]  scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RST;
      gain      <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_WIDTH: row_width <= cfg_data[ROW_W-1:0];
        CFG_GAIN:      gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_width < ROW_WIDTH_MIN)               width_eff = ROW_WIDTH_MIN;
    else if (row_width > ROW_W'(MAX_ROW_WIDTH))  width_eff = ROW_W'(MAX_ROW_WIDTH);
    else                                         width_eff = row_width;
  end

  always_comb begin
    col_start = frame_start ? '0 : col;
    row_start = frame_start ? '0 : row;
    if ({1'b0, col_start} >= width_eff) col_start = '0;
    col_inc = {1'b0, col} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      line0[clr_addr] <= '0;
      line1[clr_addr] <= '0;
    end else if (cmd.upd) begin
      line0[col] <= pix;
      line1[col] <= mid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      top_q <= line1[col];
      mid_q <= line0[col];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix   <= gray_in;
      end_q <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.accept) begin
      col <= col_start;
      row <= row_start;
    end else if (cmd.upd) begin
      if (end_q) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= width_eff) begin
        col <= '0;
        if (row != '1) row <= row + 1'b1;
      end else begin
        col <= col_inc[LINE_AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) last_q <= end_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] <= '0;
    end else if (cmd.upd) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top_q;
      win[1][2] <= mid_q;
      win[2][2] <= pix;
    end
  end

  always_comb begin
    gx = (signed'({3'b000, win[0][2]}) - signed'({3'b000, win[0][0]}))
       + ((signed'({3'b000, win[1][2]}) - signed'({3'b000, win[1][0]})) <<< 1)
       + (signed'({3'b000, win[2][2]}) - signed'({3'b000, win[2][0]}));
    gy = (signed'({3'b000, win[0][0]}) - signed'({3'b000, win[2][0]}))
       + ((signed'({3'b000, win[0][1]}) - signed'({3'b000, win[2][1]})) <<< 1)
       + (signed'({3'b000, win[0][2]}) - signed'({3'b000, win[2][2]}));
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      ax <= gx[10] ? GRAD_W'(-gx) : gx[GRAD_W-1:0];
      ay <= gy[10] ? GRAD_W'(-gy) : gy[GRAD_W-1:0];
    end
  end

  assign trial = {1'b0, res} + {1'b0, rbit};

  always_ff @(posedge clk) begin
    if (cmd.sqr) begin
      rad  <= {(21'(ax) * 21'(ax)) + (21'(ay) * 21'(ay)), 8'h00};
      res  <= '0;
      rbit <= RAD_W'(1) << (RAD_W - 1);
    end else if (cmd.root_step) begin
      if ({1'b0, rad} >= trial) begin
        rad <= rad - trial[RAD_W-1:0];
        res <= (res >> 1) + rbit;
      end else begin
        res <= res >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= PROD_W'(res[ROOT_W-1:0]) * PROD_W'(gain);
  end

  assign scaled = prod[PROD_W-1:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      edge_value  <= (|scaled[PROD_W-13:PIX_W]) ? '1 : scaled[PIX_W-1:0];
      last_result <= last_q;
    end
  end

  assign sts.clear_done = (clr_addr == '1);
  assign sts.emit       = (row >= ROWCNT_W'(2)) && (col >= LINE_AW'(2));
  assign sts.root_last  = rbit[0];
  assign sts.out_free   = !out_valid || out_ready;

  a_root_bit_live: assert property (@(posedge clk) disable iff (rst)
    cmd.root_step |-> (rbit != '0))
    else $error("square root stepped past its last bit");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd && end_q) |=> (col == '0) && (row == '0))
    else $error("counters not cleared at frame end");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> ({1'b0, col} < width_eff))
    else $error("column outside row width");

endmodule

### sv/sobel_edge_magnitude.sv
// Top level of the Sobel edge magnitude block: controller and datapath.
// Steps from input transfer to result for a pixel with a full window:
//   read, update, gradient, square, 15 square root steps, gain multiply, load.
// A new pixel is taken only once the last one is through; the load waits while the
//   result register is full, and the square root unit works one bit pair per step.
// Reset: synchronous; a clearing pass then zeroes the line stores; config always taken.
module sobel_edge_magnitude
  import sobel_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     gray_in,
  input  logic                 frame_start,
  input  logic                 frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     edge_value,
  output logic                 last_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  sobel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sobel_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .gray_in     (gray_in),
    .frame_start (frame_start),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .edge_value  (edge_value),
    .last_result (last_result)
  );

endmodule
